@@ hw/rtl/jpeg_frame_size_scanner_unit_defines.svh @@
// Assertion macros for the frame size scanner
`ifndef JPEG_FRAME_SIZE_SCANNER_UNIT_DEFINES_SVH
`define JPEG_FRAME_SIZE_SCANNER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define JFSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfss implication check failed");
`define JFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfss next-cycle check failed");
`else
`define JFSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/jfss_pkg.sv @@
package jfss_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_image;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_SIG2,
        PH_EXPECT_FF,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_FRAME
    } t_phase;

    localparam logic [7:0] C_MARK_PREFIX = 8'hFF;
    localparam logic [7:0] C_SOI         = 8'hD8;
    localparam logic [7:0] C_SOS         = 8'hDA;
    localparam logic [7:0] C_EOI         = 8'hD9;
    localparam logic [7:0] C_SOF_FIRST   = 8'hC0;
    localparam logic [7:0] C_SOF_LAST    = 8'hCF;
    localparam logic [7:0] C_DHT         = 8'hC4;
    localparam logic [7:0] C_JPG         = 8'hC8;
    localparam logic [7:0] C_DAC         = 8'hCC;

endpackage

@@ hw/rtl/jfss_core.sv @@
module jfss_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  jfss_pkg::t_in_item  i_item,
    output logic                o_emit,
    output jfss_pkg::t_out_item o_result
);
    import jfss_pkg::*;

    localparam logic [2:0] IDX_HEIGHT_HI = 3'd3;
    localparam logic [2:0] IDX_HEIGHT_LO = 3'd4;
    localparam logic [2:0] IDX_WIDTH_HI  = 3'd5;
    localparam logic [2:0] IDX_WIDTH_LO  = 3'd6;
    localparam logic [2:0] IDX_NCOMP     = 3'd7;

    t_phase      r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_hi, n_hi;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_height, n_height;
    logic [15:0] r_width, n_width;

    logic [7:0]  w_byte;
    logic [15:0] w_len;
    logic        w_sof;
    logic        w_short;

    assign w_byte  = i_item.byte_value;
    assign w_len   = {r_hi, w_byte};
    assign w_short = (r_hi == 8'h00) && (w_byte < 8'd2);
    assign w_sof   = (w_byte >= C_SOF_FIRST) && (w_byte <= C_SOF_LAST) &&
                     (w_byte != C_DHT) && (w_byte != C_JPG) && (w_byte != C_DAC);

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_hi     = r_hi;
        n_idx    = r_idx;
        n_height = r_height;
        n_width  = r_width;
        if (i_item.start_of_image) begin
            n_phase = (i_item.end_of_stream || w_byte != C_MARK_PREFIX) ? PH_DONE : PH_SIG2;
        end else if (r_phase != PH_DONE && i_item.end_of_stream) begin
            n_phase = PH_DONE;
        end else begin
            unique case (r_phase)
                PH_DONE: begin
                end
                PH_SIG2: begin
                    n_phase = (w_byte == C_SOI) ? PH_EXPECT_FF : PH_DONE;
                end
                PH_EXPECT_FF: begin
                    n_phase = (w_byte == C_MARK_PREFIX) ? PH_MARKER : PH_DONE;
                end
                PH_MARKER: begin
                    if (w_byte == C_MARK_PREFIX) begin
                        n_phase = PH_MARKER;
                    end else if (w_byte == C_SOS || w_byte == C_EOI) begin
                        n_phase = PH_DONE;
                    end else if (w_sof) begin
                        n_idx   = '0;
                        n_phase = PH_FRAME;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_hi    = w_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (w_short) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_skip  = w_len - 16'd2;
                        n_phase = (w_len == 16'd2) ? PH_EXPECT_FF : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = PH_EXPECT_FF;
                    end
                end
                PH_FRAME: begin
                    n_idx = r_idx + 3'd1;
                    case (r_idx)
                        IDX_HEIGHT_HI, IDX_WIDTH_HI: n_hi     = w_byte;
                        IDX_HEIGHT_LO:               n_height = {r_hi, w_byte};
                        IDX_WIDTH_LO:                n_width  = {r_hi, w_byte};
                        IDX_NCOMP: begin
                            n_idx   = '0;
                            n_phase = PH_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        o_emit                = 1'b0;
        o_result.found        = 1'b0;
        o_result.frame_height = '0;
        o_result.frame_width  = '0;
        if (i_item.start_of_image) begin
            o_emit = i_item.end_of_stream || (w_byte != C_MARK_PREFIX);
        end else if (r_phase != PH_DONE && i_item.end_of_stream) begin
            o_emit = 1'b1;
        end else begin
            unique case (r_phase)
                PH_SIG2:      o_emit = (w_byte != C_SOI);
                PH_EXPECT_FF: o_emit = (w_byte != C_MARK_PREFIX);
                PH_MARKER:    o_emit = (w_byte == C_SOS) || (w_byte == C_EOI);
                PH_LEN_LO:    o_emit = w_short;
                PH_FRAME: begin
                    if (r_idx == IDX_NCOMP) begin
                        o_emit                = 1'b1;
                        o_result.found        = 1'b1;
                        o_result.frame_height = r_height;
                        o_result.frame_width  = r_width;
                    end
                end
                PH_DONE, PH_LEN_HI, PH_SKIP: o_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DONE;
            r_skip   <= '0;
            r_hi     <= '0;
            r_idx    <= '0;
            r_height <= '0;
            r_width  <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_hi     <= n_hi;
            r_idx    <= n_idx;
            r_height <= n_height;
            r_width  <= n_width;
        end
    end

endmodule

@@ hw/rtl/jfss_out_reg.sv @@
module jfss_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  jfss_pkg::t_out_item i_item,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output jfss_pkg::t_out_item o_item
);
    import jfss_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hw/rtl/jpeg_frame_size_scanner_unit.sv @@
// A result passes the input register and then the result register before it is on
// o_item, and stays there while i_ready is low.
// Throughput: one byte per cycle; the input register and the result register
// each move one item a cycle while the result side takes items.
// Reset (synchronous, active low): parse goes idle waiting for a start byte,
// both stages empty.
`include "jpeg_frame_size_scanner_unit_defines.svh"
module jpeg_frame_size_scanner_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  jfss_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output jfss_pkg::t_out_item o_item
);
    import jfss_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      w_can_load;
    logic      w_advance;
    logic      w_emit;
    t_out_item w_result;

    assign w_advance = r_in_valid && w_can_load;
    assign o_ready   = !r_in_valid || w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
    end

    jfss_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    jfss_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_emit),
        .i_item     (w_result),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    `JFSS_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, w_advance && w_emit, o_valid)
    `JFSS_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    `JFSS_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && !o_item.found,
        o_item.frame_height == 16'd0 && o_item.frame_width == 16'd0)
    `JFSS_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, w_advance && w_emit, !o_valid || i_ready)

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import jfss_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_EOS,
        FLAW_CUT,
        FLAW_SIG,
        FLAW_STRAY,
        FLAW_STOP,
        FLAW_SHORT
    } t_flaw_kind;

    class t_frame_size_board;
        t_phase      phase = PH_DONE;
        logic [15:0] skip_left = '0;
        logic [7:0]  hi_byte = '0;
        logic [2:0]  frame_pos = '0;
        logic [15:0] height = '0;
        logic [15:0] width = '0;
        t_out_item   due_sizes[$];
        int          mismatches = 0;

        static function bit is_frame_code(logic [7:0] b);
            return b >= C_SOF_FIRST && b <= C_SOF_LAST && b != C_DHT && b != C_JPG
                && b != C_DAC;
        endfunction

        function int pending();
            return due_sizes.size();
        endfunction

        // Returns 1 when the item took part in a scan.
        function bit note_byte(t_in_item it);
            t_out_item   res;
            bit          emit;
            bit          active;
            logic [7:0]  b;
            logic [15:0] seg_len;
            b = it.byte_value;
            res = '0;
            emit = 1'b0;
            active = it.start_of_image || (phase != PH_DONE);
            if (it.start_of_image) begin
                if (it.end_of_stream || b != C_MARK_PREFIX) emit = 1'b1;
                else phase = PH_SIG2;
            end else if (phase == PH_DONE) begin
            end else if (it.end_of_stream) begin
                emit = 1'b1;
            end else begin
                case (phase)
                    PH_SIG2: begin
                        if (b != C_SOI) emit = 1'b1;
                        else phase = PH_EXPECT_FF;
                    end
                    PH_EXPECT_FF: begin
                        if (b != C_MARK_PREFIX) emit = 1'b1;
                        else phase = PH_MARKER;
                    end
                    PH_MARKER: begin
                        if (b == C_MARK_PREFIX) begin
                        end else if (b == C_SOS || b == C_EOI) begin
                            emit = 1'b1;
                        end else if (is_frame_code(b)) begin
                            frame_pos = '0;
                            phase = PH_FRAME;
                        end else begin
                            phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        hi_byte = b;
                        phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        seg_len = {hi_byte, b};
                        if (seg_len < 16'd2) begin
                            emit = 1'b1;
                        end else begin
                            skip_left = seg_len - 16'd2;
                            phase = (skip_left == '0) ? PH_EXPECT_FF : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == '0) phase = PH_EXPECT_FF;
                    end
                    PH_FRAME: begin
                        case (frame_pos)
                            3'd3, 3'd5: hi_byte = b;
                            3'd4: height = {hi_byte, b};
                            3'd6: width = {hi_byte, b};
                            3'd7: begin
                                emit = 1'b1;
                                res.found = 1'b1;
                                res.frame_height = height;
                                res.frame_width = width;
                            end
                            default: ;
                        endcase
                        frame_pos = frame_pos + 3'd1;
                    end
                    default: phase = PH_DONE;
                endcase
            end
            if (emit) begin
                phase = PH_DONE;
                due_sizes.push_back(res);
            end
            return active;
        endfunction

        function void check_size(t_out_item got);
            t_out_item want;
            if (due_sizes.size() == 0) begin
                $error("result with none expected: %p", got);
                mismatches++;
                return;
            end
            want = due_sizes.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
            if (got.frame_height !== want.frame_height) begin
                $error("frame_height: expected %0h, got %0h", want.frame_height,
                    got.frame_height);
                mismatches++;
            end
            if (got.frame_width !== want.frame_width) begin
                $error("frame_width: expected %0h, got %0h", want.frame_width,
                    got.frame_width);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    t_frame_size_board sizes = new();
    int bytes_parsed = 0;
    bit idle_on = 1'b1;
    bit calm = 1'b0;
    bit hold_go = 1'b0;

    jpeg_frame_size_scanner_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sizes.check_size(o_item);
    end

    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit sof, input bit eos);
        t_in_item it;
        bit taken;
        it.byte_value = b;
        it.start_of_image = sof;
        it.end_of_stream = eos;
        if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
            taken = o_ready;
            @(negedge i_clk);
        end while (!taken);
        if (sizes.note_byte(it)) bytes_parsed++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sizes.pending() != 0);
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_file();
        logic [7:0]  q[$];
        logic [7:0]  m;
        logic [15:0] seg_len;
        logic [15:0] dim;
        t_flaw_kind  flaw;
        int          nseg;
        int          cut;
        flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : t_flaw_kind'($urandom_range(1, 6));
        q.push_back(C_MARK_PREFIX);
        q.push_back(C_SOI);
        nseg = $urandom_range(0, 3);
        for (int s = 0; s <= nseg; s++) begin
            if (flaw == FLAW_STRAY && s == nseg) begin
                q.push_back(8'($urandom_range(0, 254)));
                break;
            end
            repeat ($urandom_range(1, 3)) q.push_back(C_MARK_PREFIX);
            if (flaw == FLAW_STOP && s == nseg) begin
                q.push_back($urandom_range(0, 1) ? C_SOS : C_EOI);
                break;
            end
            if (s < nseg || flaw == FLAW_SHORT) begin
                do m = 8'($urandom_range(0, 254));
                while (t_frame_size_board::is_frame_code(m) || m == C_SOS || m == C_EOI);
                q.push_back(m);
                if (s == nseg) begin
                    q.push_back(8'h00);
                    q.push_back(8'($urandom_range(0, 1)));
                end else begin
                    seg_len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 768))
                                                            : 16'($urandom_range(2, 10));
                    q.push_back(seg_len[15:8]);
                    q.push_back(seg_len[7:0]);
                    repeat (int'(seg_len) - 2) q.push_back(8'($urandom));
                end
            end else begin
                do m = 8'($urandom_range(C_SOF_FIRST, C_SOF_LAST));
                while (!t_frame_size_board::is_frame_code(m));
                q.push_back(m);
                repeat (3) q.push_back(8'($urandom));
                dim = pick_dim();
                q.push_back(dim[15:8]);
                q.push_back(dim[7:0]);
                dim = pick_dim();
                q.push_back(dim[15:8]);
                q.push_back(dim[7:0]);
                q.push_back(8'($urandom));
            end
        end
        if (flaw == FLAW_SIG) begin
            cut = $urandom_range(0, 1);
            q[cut] = q[cut] ^ 8'($urandom_range(1, 255));
        end
        if (flaw == FLAW_EOS || flaw == FLAW_CUT) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut) void'(q.pop_back());
        end
        foreach (q[i]) send_byte(q[i], i == 0, 1'b0);
        if (flaw == FLAW_EOS) send_byte(8'($urandom), 1'b0, 1'b1);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0,
                1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        bit pressed;
        pressed = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_byte(C_MARK_PREFIX, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(C_MARK_PREFIX, 1'b1, 1'b0);
        send_byte(C_SOI, 1'b0, 1'b0);
        send_byte(C_MARK_PREFIX, 1'b0, 1'b0);
        send_byte(C_MARK_PREFIX, 1'b0, 1'b0);
        send_byte(C_SOF_LAST, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte(8'h08, 1'b0, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(C_MARK_PREFIX, 1'b1, 1'b0);
        send_byte(C_SOI, 1'b0, 1'b0);
        send_byte(C_MARK_PREFIX, 1'b0, 1'b0);
        send_byte(C_EOI, 1'b0, 1'b0);
        send_byte(C_MARK_PREFIX, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        while (bytes_parsed < 1650) begin
            calm = ($urandom_range(0, 4) == 0);
            if (!pressed && bytes_parsed >= 800) begin
                pressed = 1'b1;
                hold_go = 1'b1;
                repeat (30) send_byte(8'($urandom_range(0, 254)), 1'b1, 1'b0);
                drain();
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0,
                        $urandom_range(0, 5) == 0);
                end
            end else begin
                random_file();
            end
        end
        idle_on = 1'b0;
        while (bytes_parsed < 1950) random_file();

        drain();
        repeat (8) @(negedge i_clk);
        if (sizes.mismatches == 0 && sizes.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/jfss_pkg.sv
hw/rtl/jfss_core.sv
hw/rtl/jfss_out_reg.sv
hw/rtl/jpeg_frame_size_scanner_unit.sv
tb/sv/tb.sv
